### src/urmf_pkg.sv
`default_nettype none
package urmf_pkg;

   // Number of receive channels, numbered 1 to NCH on the ports.
   localparam int NCH = 3;

   // Buffer geometry and idle countdown width.
   localparam int BUF_DEPTH   = 256;
   localparam int COUNT_WIDTH = 16;
   localparam int IDX_W       = $clog2(BUF_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUF_DEPTH - 1);

   // Field widths fixed by the interface.
   localparam int RELOAD_W = 16;
   localparam int CSR_W    = 48;

   // Operation codes.
   localparam logic [1:0] OP_BYTE  = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Event codes.
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_STORED   = 3'd1;
   localparam logic [2:0] EV_FORWARD  = 3'd2;
   localparam logic [2:0] EV_TERM     = 3'd3;
   localparam logic [2:0] EV_TIMEOUT  = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BRIDGE_TARGETS   = 2'd0;
   localparam logic [1:0] CSR_TERMINATOR_MODES = 2'd1;
   localparam logic [1:0] CSR_TERMINATOR_CHARS = 2'd2;
   localparam logic [1:0] CSR_IDLE_RELOADS     = 2'd3;

   typedef struct packed {
      logic [NCH-1:0][1:0]          bridge_targets;
      logic [NCH-1:0]               terminator_modes;
      logic [NCH-1:0][7:0]          terminator_chars;
      logic [NCH-1:0][RELOAD_W-1:0] idle_reloads;
   } cfg_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [1:0] channel;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]     event_res;
      logic [1:0]     event_channel;
      logic [7:0]     out_byte;
      logic [7:0]     store_index;
      logic [1:0]     forward_channel;
      logic           buffer_full;
      logic [NCH-1:0] ready_flags;
   } rsp_type;

endpackage : urmf_pkg
`default_nettype wire

### src/uart_rx_message_framer_unit.sv
// Three-channel UART receive message framer.
// Input beats arrive on the req_ stream: req_tuser carries the operation
// (byte, tick or clear) and the channel, req_tdata the received byte.
// Every accepted beat produces exactly one result beat on the rsp_ stream,
// carrying the event code, channel, byte, buffer index, forward target,
// buffer-full flag and the ready flags after the step.
// Configuration registers are written through csr_we/csr_index/csr_wdata,
// one register per cycle with no wait. The user must write them only while
// the stream is idle; the block itself does not enforce this.
// Each beat passes through the input register and then the result register.
// Throughput is one beat per cycle while the receiver takes results: a single
// input register feeds short combinational framing logic that updates the
// per-channel index, countdown and ready flag and loads the result register
// in the same cycle. When the receiver stalls, the result register holds its
// beat and the input register still takes one more beat, so req_tready drops
// only when both stages are full.
// A synchronous reset empties both stages and clears all configuration
// registers, write indexes, countdowns and ready flags.
`default_nettype none
module uart_rx_message_framer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input stream.
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic [3:0]  req_tuser,   // [1:0] operation, [3:2] channel
   // Result stream.
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata,   // [7:0] out_byte, [15:8] store_index,
                                         // [16] buffer_full, [19:17] ready_flags,
                                         // [23:20] zero
   output      logic [6:0]  rsp_tuser,   // [2:0] event_res, [4:3] event_channel,
                                         // [6:5] forward_channel
   // Configuration write port.
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [47:0] csr_wdata
);
   import urmf_pkg::*;

   cfg_type cfg;
   rsp_type res;

   req_type in_ff, in_in;
   logic    in_valid_ff, in_valid_in;
   rsp_type out_ff;
   logic    out_valid_ff, out_valid_in;
   logic    advance;

   // The input stage moves into the result register whenever the result
   // register is empty or is being drained in this cycle.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_in       = in_ff;
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_in.operation = req_tuser[1:0];
         in_in.channel   = req_tuser[3:2];
         in_in.rx_byte   = req_tdata;
         in_valid_in     = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_ff <= in_in;
      if (advance) begin
         out_ff <= res;
      end
   end

   urmf_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Channel state is committed only when the beat moves on, so each beat
   // sees the state left by the one before it.
   urmf_channel_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_ff),
      .cfg   (cfg),
      .res   (res)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_ff.ready_flags, out_ff.buffer_full,
                        out_ff.store_index, out_ff.out_byte};
   assign rsp_tuser  = {out_ff.forward_channel, out_ff.event_channel, out_ff.event_res};

   // A waiting input beat stays put until it can move on.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
      else $error("input stage lost a beat while the result register was stalled");

   // An event names a channel exactly when there is an event.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_ff.event_res == EV_NONE) == (out_ff.event_channel == 2'd0)))
      else $error("event channel does not match event code");

   // Only forwarded bytes carry a target; only plain stores report a full buffer.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_ff.forward_channel != 2'd0) == (out_ff.event_res == EV_FORWARD))
                       && (!out_ff.buffer_full || out_ff.event_res == EV_STORED))
      else $error("forward target or buffer-full flag on the wrong event");

   // A completion always leaves that channel's ready flag set.
   assert property (@(posedge clock) disable iff (reset)
      advance && (res.event_res == EV_TERM || res.event_res == EV_TIMEOUT)
         |-> res.ready_flags[res.event_channel - 2'd1])
      else $error("completed message without ready flag");

endmodule : uart_rx_message_framer_unit
`default_nettype wire

### src/urmf_csr_regs.sv
`default_nettype none
module urmf_csr_regs (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [1:0]                csr_index,
   input  wire logic [urmf_pkg::CSR_W-1:0] csr_wdata,
   output      urmf_pkg::cfg_type         cfg
);
   import urmf_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BRIDGE_TARGETS:   cfg_in.bridge_targets   = csr_wdata[2*NCH-1:0];
            CSR_TERMINATOR_MODES: cfg_in.terminator_modes = csr_wdata[NCH-1:0];
            CSR_TERMINATOR_CHARS: cfg_in.terminator_chars = csr_wdata[8*NCH-1:0];
            CSR_IDLE_RELOADS:     cfg_in.idle_reloads     = csr_wdata[RELOAD_W*NCH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule : urmf_csr_regs
`default_nettype wire

### src/urmf_channel_core.sv
`default_nettype none
module urmf_channel_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire urmf_pkg::req_type req,
   input  wire urmf_pkg::cfg_type cfg,
   output      urmf_pkg::rsp_type res
);
   import urmf_pkg::*;

   logic [NCH-1:0][IDX_W-1:0]       wi_ff, wi_in;
   logic [NCH-1:0][COUNT_WIDTH-1:0] cd_ff, cd_in;
   logic [NCH-1:0]                  rdy_ff, rdy_in;

   logic [1:0]                      k;
   logic [1:0]                      tgt;
   logic [IDX_W-1:0]                idx;
   logic [IDX_W+7:0]                idx_ext;
   logic [COUNT_WIDTH+RELOAD_W-1:0] reload_ext;
   logic                            found;

   always_comb begin
      wi_in      = wi_ff;
      cd_in      = cd_ff;
      rdy_in     = rdy_ff;
      res        = '0;
      res.event_res = EV_NONE;
      k          = req.channel - 2'd1;
      tgt        = cfg.bridge_targets[k];
      idx        = wi_ff[k];
      idx_ext    = {8'd0, idx};
      reload_ext = {{COUNT_WIDTH{1'b0}}, cfg.idle_reloads[k]};
      found      = 1'b0;
      case (req.operation)
         OP_BYTE: begin
            if (req.channel != 2'd0) begin
               res.event_channel = req.channel;
               res.out_byte      = req.rx_byte;
               if (tgt != 2'd0) begin
                  res.event_res       = EV_FORWARD;
                  res.forward_channel = tgt;
               end else begin
                  res.store_index = idx_ext[7:0];
                  if (cfg.terminator_modes[k] && req.rx_byte == cfg.terminator_chars[k]) begin
                     res.event_res = EV_TERM;
                     wi_in[k]      = '0;
                     rdy_in[k]     = 1'b1;
                  end else begin
                     res.event_res = EV_STORED;
                     if (!cfg.terminator_modes[k]) begin
                        cd_in[k] = reload_ext[COUNT_WIDTH-1:0];
                     end
                     if (idx == IDX_LAST) begin
                        res.buffer_full = 1'b1;
                     end else begin
                        wi_in[k] = idx + 1'b1;
                     end
                  end
               end
            end
         end
         OP_TICK: begin
            // Only the lowest-numbered channel holding a partial message is served.
            for (int c = 0; c < NCH; c++) begin
               if (!found && wi_ff[c] != '0) begin
                  found = 1'b1;
                  if (cd_ff[c] == '0) begin
                     wi_in[c]          = '0;
                     rdy_in[c]         = 1'b1;
                     res.event_res     = EV_TIMEOUT;
                     res.event_channel = 2'(c + 1);
                  end else begin
                     cd_in[c] = cd_ff[c] - 1'b1;
                  end
               end
            end
         end
         OP_CLEAR: begin
            if (req.channel != 2'd0) begin
               rdy_in[k] = 1'b0;
            end
         end
         default: ;
      endcase
      res.ready_flags = rdy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wi_ff  <= '0;
         cd_ff  <= '0;
         rdy_ff <= '0;
      end else if (step) begin
         wi_ff  <= wi_in;
         cd_ff  <= cd_in;
         rdy_ff <= rdy_in;
      end
   end

endmodule : urmf_channel_core
`default_nettype wire

### tb/tb_uart_rx_message_framer_unit.sv
module tb_uart_rx_message_framer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import urmf_pkg::*;

   // The block decodes operation 3 as nothing, so the bench gives it a name of its own.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Each beat passes the input and result registers before its result is offered. The
   // extra cycles at each drain give the pipeline time to settle before a register write.
   localparam int DRAIN_CYCLES  = 6;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_BEATS   = 80;

   // The idle profile of each random phase. The sender idle rate and the receiver
   // stall rate are given in percent and are indexed by phase modulo four.
   localparam int SEND_IDLE  [4] = '{0, 80, 0, 7};
   localparam int RECV_STALL [4] = '{0, 0, 80, 7};

   // A directed row carries one input beat. When the row is marked typed, it also
   // carries the result written out by hand. The section number selects the
   // register setting that is loaded before the first row of that section.
   typedef struct packed {
      logic [1:0] section;
      logic [1:0] op;
      logic [1:0] ch;
      logic [7:0] rx;
      logic       typed;
      rsp_type    want;
   } dir_row_type;

   localparam cfg_type SECTION_CFG [3] = '{
      '{6'h00, 3'h0, 24'h00_0000, 48'h0000_0000_0000},
      '{6'h3C, 3'h1, 24'h00_000A, 48'hFFFF_0001_0002},
      '{6'h00, 3'h0, 24'hFF_FFFF, 48'h0000_0002_0000}
   };

   localparam int DIR_COUNT = 23;
   localparam dir_row_type DIRECTED_ROWS [DIR_COUNT] = '{
      // After reset every channel buffers its bytes, uses idle framing and has a
      // reload of zero.
      '{2'd0, OP_TICK,   2'd0, 8'h00, 1'b1, '{EV_NONE,    2'd0, 8'h00, 8'h00, 2'd0, 1'b0, 3'b000}},
      '{2'd0, OP_BYTE,   2'd1, 8'h00, 1'b1, '{EV_STORED,  2'd1, 8'h00, 8'h00, 2'd0, 1'b0, 3'b000}},
      '{2'd0, OP_BYTE,   2'd1, 8'hFF, 1'b1, '{EV_STORED,  2'd1, 8'hFF, 8'h01, 2'd0, 1'b0, 3'b000}},
      '{2'd0, OP_BYTE,   2'd3, 8'h5A, 1'b1, '{EV_STORED,  2'd3, 8'h5A, 8'h00, 2'd0, 1'b0, 3'b000}},
      '{2'd0, OP_TICK,   2'd2, 8'h77, 1'b1, '{EV_TIMEOUT, 2'd1, 8'h00, 8'h00, 2'd0, 1'b0, 3'b001}},
      '{2'd0, OP_TICK,   2'd0, 8'h00, 1'b1, '{EV_TIMEOUT, 2'd3, 8'h00, 8'h00, 2'd0, 1'b0, 3'b101}},
      '{2'd0, OP_CLEAR,  2'd1, 8'h00, 1'b1, '{EV_NONE,    2'd0, 8'h00, 8'h00, 2'd0, 1'b0, 3'b100}},
      '{2'd0, OP_UNUSED, 2'd3, 8'hFF, 1'b1, '{EV_NONE,    2'd0, 8'h00, 8'h00, 2'd0, 1'b0, 3'b100}},
      '{2'd0, OP_BYTE,   2'd0, 8'hA5, 1'b1, '{EV_NONE,    2'd0, 8'h00, 8'h00, 2'd0, 1'b0, 3'b100}},
      '{2'd0, OP_CLEAR,  2'd0, 8'h00, 1'b1, '{EV_NONE,    2'd0, 8'h00, 8'h00, 2'd0, 1'b0, 3'b100}},
      '{2'd0, OP_CLEAR,  2'd3, 8'h00, 1'b1, '{EV_NONE,    2'd0, 8'h00, 8'h00, 2'd0, 1'b0, 3'b000}},
      // Channel 2 bridges to channel 3, and channel 3 bridges to itself. Channel 1
      // ends its messages on a line feed.
      '{2'd1, OP_BYTE,   2'd2, 8'h11, 1'b1, '{EV_FORWARD, 2'd2, 8'h11, 8'h00, 2'd3, 1'b0, 3'b000}},
      '{2'd1, OP_BYTE,   2'd3, 8'h80, 1'b1, '{EV_FORWARD, 2'd3, 8'h80, 8'h00, 2'd3, 1'b0, 3'b000}},
      '{2'd1, OP_BYTE,   2'd1, 8'h41, 1'b0, '0},
      '{2'd1, OP_BYTE,   2'd1, 8'h0A, 1'b1, '{EV_TERM,    2'd1, 8'h0A, 8'h01, 2'd0, 1'b0, 3'b001}},
      '{2'd1, OP_TICK,   2'd0, 8'h00, 1'b1, '{EV_NONE,    2'd0, 8'h00, 8'h00, 2'd0, 1'b0, 3'b001}},
      // A channel that uses terminator framing still times out on a tick.
      '{2'd1, OP_BYTE,   2'd1, 8'h42, 1'b0, '0},
      '{2'd1, OP_TICK,   2'd0, 8'h00, 1'b0, '0},
      // Channel 2 reloads its countdown to two. The message completes on the third tick.
      '{2'd2, OP_BYTE,   2'd2, 8'h33, 1'b0, '0},
      '{2'd2, OP_TICK,   2'd0, 8'h00, 1'b0, '0},
      '{2'd2, OP_TICK,   2'd0, 8'h00, 1'b0, '0},
      '{2'd2, OP_TICK,   2'd0, 8'h00, 1'b0, '0},
      '{2'd2, OP_BYTE,   2'd1, 8'hFF, 1'b0, '0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;     // [7:0] rx_byte
   logic [3:0]  req_tuser = '0;     // [1:0] operation, [3:2] channel
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;          // [7:0] out_byte, [15:8] store_index, [16] buffer_full,
                                    // [19:17] ready_flags, [23:20] zero
   logic [6:0]  rsp_tuser;          // [2:0] event_res, [4:3] event_channel,
                                    // [6:5] forward_channel
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [47:0] csr_wdata = '0;

   // The framer model has a copy of the registers and of each channel's state.
   // It is stepped once for each input beat that the block accepts.
   cfg_type                cfg = '0;
   logic [IDX_W-1:0]       wr_idx    [NCH] = '{default: '0};
   logic [COUNT_WIDTH-1:0] countdown [NCH] = '{default: '0};
   logic [NCH-1:0]         ready_vec = '0;

   // The expected result of each accepted beat is queued here, oldest first.
   rsp_type     expected_events [$];
   int          mismatches     = 0;
   int          beats_sent     = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int unsigned cycle_count    = 0;

   uart_rx_message_framer_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Apply one beat to the framer model and return the result event.
   function automatic rsp_type next_event(input logic [1:0] op, input logic [1:0] ch,
                                          input logic [7:0] rx);
      rsp_type          r;
      int               k;
      bit               found;
      logic [IDX_W-1:0] idx;
      r = '0;
      found = 1'b0;
      if (op == OP_BYTE && ch != 2'd0) begin
         k = int'(ch) - 1;
         r.event_channel = ch;
         r.out_byte = rx;
         if (cfg.bridge_targets[k] != 2'd0) begin
            r.event_res = EV_FORWARD;
            r.forward_channel = cfg.bridge_targets[k];
         end else begin
            idx = wr_idx[k];
            r.store_index = 8'(idx);
            if (cfg.terminator_modes[k] && rx == cfg.terminator_chars[k]) begin
               r.event_res = EV_TERM;
               wr_idx[k] = '0;
               ready_vec[k] = 1'b1;
            end else begin
               if (!cfg.terminator_modes[k])
                  countdown[k] = COUNT_WIDTH'(cfg.idle_reloads[k]);
               r.event_res = EV_STORED;
               // When the index is at the last slot, it stays there and later bytes
               // overwrite that slot.
               if (idx == IDX_LAST)
                  r.buffer_full = 1'b1;
               else
                  wr_idx[k] = idx + 1'b1;
            end
         end
      end else if (op == OP_TICK) begin
         // Only the lowest-numbered channel that holds a partial message sees the tick.
         for (k = 0; k < NCH; k++) begin
            if (!found && wr_idx[k] != '0) begin
               found = 1'b1;
               if (countdown[k] == '0) begin
                  wr_idx[k] = '0;
                  ready_vec[k] = 1'b1;
                  r.event_res = EV_TIMEOUT;
                  r.event_channel = 2'(k + 1);
               end else begin
                  countdown[k] = countdown[k] - 1'b1;
               end
            end
         end
      end else if (op == OP_CLEAR && ch != 2'd0) begin
         ready_vec[int'(ch) - 1] = 1'b0;
      end
      r.ready_flags = ready_vec;
      return r;
   endfunction

   // Drive one beat, wait for the handshake, and then queue the result that the
   // beat should produce.
   task automatic send_beat(input logic [1:0] op, input logic [1:0] ch, input logic [7:0] rx,
                            input bit typed, input rsp_type want);
      rsp_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      req_tuser  <= {ch, op};
      do @(posedge clock); while (!req_tready);
      predicted = next_event(op, ch, rx);
      expected_events.push_back(typed ? want : predicted);
      beats_sent++;
   endtask

   // Stop sending and wait until every queued result has arrived. Then allow a few
   // more cycles so that the pipeline is empty.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_events.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all four registers on consecutive cycles while the block is idle. The
   // bits above each register's width get random values, and the block must
   // ignore them.
   task automatic load_config(input cfg_type c);
      logic [1:0]  idx;
      logic [47:0] val;
      drain_results();
      for (int i = 0; i < 4; i++) begin
         idx = 2'(i);
         val = {16'($urandom), 32'($urandom)};
         case (idx)
            CSR_BRIDGE_TARGETS:   val[5:0]  = c.bridge_targets;
            CSR_TERMINATOR_MODES: val[2:0]  = c.terminator_modes;
            CSR_TERMINATOR_CHARS: val[23:0] = c.terminator_chars;
            default:              val       = c.idle_reloads;
         endcase
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= val;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cfg = c;
   endtask

   // Send one message to a channel. In terminator framing the body mostly avoids the
   // terminator byte and the message usually ends with it. A long message always
   // ends with the terminator, so a full buffer is followed by a completion. In
   // idle framing the message is followed by the reload plus zero to three ticks if
   // the reload is at most six, else by one to four. A clear may come after either kind.
   task automatic run_message(input logic [1:0] ch, input int len);
      int         k;
      int         ticks;
      bit         framed;
      logic [7:0] term;
      logic [7:0] rx;
      k = int'(ch) - 1;
      framed = cfg.terminator_modes[k];
      term = cfg.terminator_chars[k];
      for (int i = 0; i < len; i++) begin
         rx = 8'($urandom);
         if (framed && rx == term && (len > 20 || $urandom_range(0, 7) != 0))
            rx = rx ^ 8'h01;
         send_beat(OP_BYTE, ch, rx, 1'b0, '0);
      end
      if (framed && (len > 20 || $urandom_range(0, 99) < 85))
         send_beat(OP_BYTE, ch, term, 1'b0, '0);
      if (framed)
         ticks = $urandom_range(0, 2);
      else if (cfg.idle_reloads[k] > 16'd6)
         ticks = $urandom_range(1, 4);
      else
         ticks = int'(cfg.idle_reloads[k]) + $urandom_range(0, 3);
      // A tick ignores its channel and byte fields, so those fields get random values.
      repeat (ticks) send_beat(OP_TICK, 2'($urandom), 8'($urandom), 1'b0, '0);
      if ($urandom_range(0, 1) == 0)
         send_beat(OP_CLEAR, ch, 8'($urandom), 1'b0, '0);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // The receiver checks each accepted result beat against the oldest expectation,
   // field by field. Then it decides whether to stall in the next cycle.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.out_byte        = rsp_tdata[7:0];
            got.store_index     = rsp_tdata[15:8];
            got.buffer_full     = rsp_tdata[16];
            got.ready_flags     = rsp_tdata[19:17];
            got.event_res       = rsp_tuser[2:0];
            got.event_channel   = rsp_tuser[4:3];
            got.forward_channel = rsp_tuser[6:5];
            if (expected_events.size() == 0) begin
               $display("%0t: no result expected, got tuser %h tdata %h",
                        $time, rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_events.pop_front();
               check_field("event_res", want.event_res, got.event_res);
               check_field("event_channel", want.event_channel, got.event_channel);
               check_field("out_byte", want.out_byte, got.out_byte);
               check_field("store_index", want.store_index, got.store_index);
               check_field("forward_channel", want.forward_channel, got.forward_channel);
               check_field("buffer_full", want.buffer_full, got.buffer_full);
               check_field("ready_flags", want.ready_flags, got.ready_flags);
               check_field("tdata padding", 0, rsp_tdata[23:20]);
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // The watchdog stops a run that hangs. The limit is many times the length of a
   // slow but correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_events.size());
         $display("[uart_rx_message_framer_unit] ERROR");
         $finish;
      end
   end

   initial begin
      int      last_section;
      int      phase_start;
      bit      paused;
      cfg_type pc;
      last_section = -1;
      paused = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Each section starts from an idle block with its own register
      // setting. Rows without a hand-written result are checked against the model.
      for (int r = 0; r < DIR_COUNT; r++) begin
         if (int'(DIRECTED_ROWS[r].section) != last_section) begin
            last_section = int'(DIRECTED_ROWS[r].section);
            load_config(SECTION_CFG[last_section]);
         end
         send_beat(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].ch, DIRECTED_ROWS[r].rx,
                   DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
      end

      // Random part. Phases 0 to 3 use mostly fixed settings that include the extremes of
      // each register. Later phases draw a mixed setting in which most channels
      // buffer their bytes. Phase 0 fills channel 1's buffer to the end.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: pc = '{6'h00, 3'h7, 24'($urandom), 48'h0000_0003_0001};
            1: pc = '{6'h00, 3'h0, 24'h00_0000, 48'h0000_0000_0000};
            2: pc = '{6'h3F, 3'h7, 24'hFF_FFFF, 48'hFFFF_FFFF_FFFF};
            3: pc = '{6'h00, 3'h0, 24'hFF_FFFF, 48'hFFFF_FFFF_FFFF};
            default: begin
               for (int k = 0; k < NCH; k++) begin
                  pc.bridge_targets[k] = ($urandom_range(0, 3) == 0) ?
                                         2'($urandom_range(1, 3)) : 2'd0;
                  pc.terminator_chars[k] = 8'($urandom);
                  pc.idle_reloads[k] = 16'($urandom_range(0, 5));
               end
               pc.terminator_modes = 3'($urandom);
            end
         endcase
         load_config(pc);
         send_idle_pct  = SEND_IDLE[phase % 4];
         recv_stall_pct = RECV_STALL[phase % 4];

         phase_start = beats_sent;
         if (phase == 0)
            run_message(2'd1, $urandom_range(256, 262));
         while (beats_sent - phase_start < PHASE_BEATS) begin
            // Once in the run the sender stops partway through a phase and waits
            // until every result has arrived.
            if (phase == 5 && !paused && beats_sent - phase_start >= PHASE_BEATS / 2) begin
               drain_results();
               paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 80)
               run_message(2'($urandom_range(1, 3)), $urandom_range(1, 10));
            else
               repeat ($urandom_range(1, 4))
                  send_beat(2'($urandom), 2'($urandom), 8'($urandom), 1'b0, '0);
         end
      end

      drain_results();
      if (mismatches == 0 && expected_events.size() == 0)
         $display("[uart_rx_message_framer_unit] OK");
      else
         $display("[uart_rx_message_framer_unit] ERROR");
      $finish;
   end

endmodule
